### hw/rtl/http_request_id_extractor_macros.svh
// ----------------------------------------------------------------------------
// HTTP request id extractor assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_ID_EXTRACTOR_MACROS_SVH
`define HTTP_REQUEST_ID_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define HRE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hre same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define HRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hre next-cycle check failed");

`endif

### hw/rtl/hre_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request id extractor package
// Parser state codes, event codes, limits and the step result bundle.
// ----------------------------------------------------------------------------
package hre_pkg;

    // Longest id that is kept; later id bytes are dropped.
    localparam logic [7:0] MAX_ID_LEN = 8'd32;

    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_J     = 8'h6A;
    localparam logic [7:0] CHR_S     = 8'h73;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;

    // Event codes carried on the result channel.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_ID_BYTE  = 3'd1;
    localparam logic [2:0] EV_ID_END   = 3'd2;
    localparam logic [2:0] EV_COMPLETE = 3'd3;
    localparam logic [2:0] EV_REJECT   = 3'd4;

    typedef enum logic [3:0] {
        ST_WAIT_SLASH = 4'd0,
        ST_ID         = 4'd1,
        ST_WANT_J     = 4'd2,
        ST_WANT_S     = 4'd3,
        ST_LINE       = 4'd4,
        ST_LINE_LF    = 4'd5,
        ST_HDR        = 4'd6,
        ST_HDR_LF     = 4'd7,
        ST_HDR_CR2    = 4'd8,
        ST_HDR_LF2    = 4'd9,
        ST_DONE       = 4'd10,
        ST_REJECTED   = 4'd11
    } parse_state_t;

    // Outcome of one byte: updated parser state plus the result fields.
    typedef struct packed {
        parse_state_t state;
        logic [7:0]   id_count;
        logic [2:0]   ev;
        logic [7:0]   ch;
    } step_res_t;

endpackage

### hw/rtl/hre_step.sv
// ----------------------------------------------------------------------------
// HTTP request id extractor step logic
// Combinational transition of the parser for one request byte.
// ----------------------------------------------------------------------------
module hre_step
    import hre_pkg::*;
(
    input  parse_state_t state,
    input  logic [7:0]   id_count,
    input  logic         new_connection,
    input  logic [7:0]   data_byte,
    output step_res_t    res
);

    parse_state_t cur_state;
    logic [7:0]   cur_count;

    // A new connection clears the parser before the byte is looked at.
    assign cur_state = new_connection ? ST_WAIT_SLASH : state;
    assign cur_count = new_connection ? 8'd0 : id_count;

    always_comb
    begin
        res.state    = cur_state;
        res.id_count = cur_count;
        res.ev       = EV_NONE;
        res.ch       = 8'd0;
        case (cur_state)
            ST_WAIT_SLASH:
            begin
                if (data_byte == CHR_SLASH)
                begin
                    res.state    = ST_ID;
                    res.id_count = 8'd0;
                end
            end
            ST_ID:
            begin
                if (data_byte == CHR_DOT)
                begin
                    res.state = ST_WANT_J;
                    res.ev    = EV_ID_END;
                end
                else if (cur_count < MAX_ID_LEN)
                begin
                    res.id_count = cur_count + 8'd1;
                    res.ev       = EV_ID_BYTE;
                    res.ch       = data_byte;
                end
            end
            ST_WANT_J:
            begin
                if (data_byte == CHR_J)
                begin
                    res.state = ST_WANT_S;
                end
                else
                begin
                    res.state = ST_REJECTED;
                    res.ev    = EV_REJECT;
                end
            end
            ST_WANT_S:
            begin
                if (data_byte == CHR_S)
                begin
                    res.state = ST_LINE;
                end
                else
                begin
                    res.state = ST_REJECTED;
                    res.ev    = EV_REJECT;
                end
            end
            ST_LINE:
            begin
                if (data_byte == CHR_CR)
                begin
                    res.state = ST_LINE_LF;
                end
            end
            ST_LINE_LF:
            begin
                if (data_byte == CHR_LF)
                begin
                    res.state = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (data_byte == CHR_CR)
                begin
                    res.state = ST_HDR_LF;
                end
            end
            ST_HDR_LF:
            begin
                if (data_byte == CHR_LF)
                begin
                    res.state = ST_HDR_CR2;
                end
            end
            ST_HDR_CR2:
            begin
                res.state = (data_byte == CHR_CR) ? ST_HDR_LF2 : ST_HDR;
            end
            ST_HDR_LF2:
            begin
                if (data_byte == CHR_LF)
                begin
                    res.state = ST_DONE;
                    res.ev    = EV_COMPLETE;
                end
            end
            default:
            begin
                res.state = cur_state;
            end
        endcase
    end

endmodule

### hw/rtl/http_request_id_extractor.sv
// ----------------------------------------------------------------------------
// HTTP request id extractor
// Byte-serial parser that pulls the client id out of an HTTP request line.
// ----------------------------------------------------------------------------
// Usage: the sender presents one request byte per item on data_byte, with
// new_connection high on the first byte of a new connection so that the
// parser starts clean. Every accepted item yields exactly one result item:
// event_res, the id byte in id_char when the event is an id byte, and the
// number of id bytes stored so far in id_length.
// Both channels use valid and stall; an item moves at a rising edge where
// valid is high and stall is low.
// An item accepted sits in the input register and moves into the result
// register when that register is free, at which point out_valid rises.
// Throughput is one item per cycle while the receiver does not stall; the
// parser state registers are updated as each item moves into the result
// register. When the receiver stalls, the result register holds its item
// and the input register can still take one more item; only when both are
// full is in_stall raised.
// Reset clears both valid flags and returns the parser to waiting for the
// slash with an id length of zero.
// ----------------------------------------------------------------------------
module http_request_id_extractor
    import hre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       new_connection,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic [7:0] id_char,
    output logic [7:0] id_length
);

    // Input register.
    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic         s1_nc_reg;
    logic [7:0]   s1_byte_reg;

    // Parser state, advanced once per item leaving the input register.
    parse_state_t state_reg;
    logic [7:0]   id_count_reg;

    // Result register.
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [2:0]   event_res_reg;
    logic [7:0]   id_char_reg;
    logic [7:0]   id_length_reg;

    logic         out_free;
    logic         advance;
    logic         accept_in;
    step_res_t    step;

    // The result register can take a new item when it is empty or draining.
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign accept_in = in_valid && !in_stall;

    hre_step u_step (
        .state          (state_reg),
        .id_count       (id_count_reg),
        .new_connection (s1_nc_reg),
        .data_byte      (s1_byte_reg),
        .res            (step)
    );

    always_comb
    begin
        if (accept_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_WAIT_SLASH;
            id_count_reg  <= 8'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg    <= step.state;
                id_count_reg <= step.id_count;
            end
        end
    end

    // Payload registers load only on a handshake, so a stalled item holds.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_nc_reg   <= new_connection;
            s1_byte_reg <= data_byte;
        end
        if (advance)
        begin
            event_res_reg <= step.ev;
            id_char_reg   <= step.ch;
            id_length_reg <= step.id_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_res_reg;
    assign id_char   = id_char_reg;
    assign id_length = id_length_reg;

endmodule

### hw/rtl/hre_checker.sv
// ----------------------------------------------------------------------------
// HTTP request id extractor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "http_request_id_extractor_macros.svh"

module hre_checker
    import hre_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] event_res,
    input logic [7:0] id_char,
    input logic [7:0] id_length
);

    // Only the five defined events may appear.
    `HRE_ASSERT_SAME(a_event_legal, out_valid, event_res <= EV_REJECT)

    // The stored id never grows past its limit.
    `HRE_ASSERT_SAME(a_length_limit, out_valid, id_length <= MAX_ID_LEN)

    // An id byte always counts toward the stored length.
    `HRE_ASSERT_SAME(a_byte_counted, out_valid && event_res == EV_ID_BYTE,
        id_length != 8'd0)

    // Id character is zero for every event other than an id byte.
    `HRE_ASSERT_SAME(a_char_zero, out_valid && event_res != EV_ID_BYTE,
        id_char == 8'd0)

    // A stalled result stays put.
    `HRE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(event_res) && $stable(id_char) && $stable(id_length))

endmodule

bind http_request_id_extractor hre_checker u_hre_checker (.*);
